>>> rtl/core/phcb_pkg.sv
`default_nettype none

package phcb_pkg;

    typedef enum logic
    {
        MODE_ICMP = 1'b0,
        MODE_UDP  = 1'b1
    } proto_mode_t;

    typedef enum logic [2:0]
    {
        REG_PROTOCOL_MODE       = 3'd0,
        REG_DST_PORT            = 3'd1,
        REG_SRC_PORT            = 3'd2,
        REG_PROCESS_ID          = 3'd3,
        REG_SOURCE_ADDRESS      = 3'd4,
        REG_DESTINATION_ADDRESS = 3'd5,
        REG_FILL_BYTE           = 3'd6,
        REG_PROBE_LENGTH        = 3'd7
    } cfg_reg_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [15:0] ICMP_ECHO_WORD     = 16'h0800;
    localparam logic [15:0] UDP_PROTO_NUM      = 16'd17;
    localparam logic [15:0] ICMP_MIN_LEN       = 16'd8;
    localparam logic [15:0] UDP_MIN_LEN        = 16'd12;
    localparam logic [15:0] HDR_BYTES          = 16'd8;
    localparam logic [15:0] CORR_FILL_START    = 16'd10;
    localparam logic [15:0] ALL_ONES_WORD      = 16'hffff;
    localparam logic [15:0] PROBE_LENGTH_RESET = 16'd64;

    typedef struct packed
    {
        proto_mode_t protocol_mode;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [15:0] process_id;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  fill_byte;
        logic [15:0] probe_length;
    } cfg_t;

    typedef struct packed
    {
        logic [15:0] header_word_0;
        logic [15:0] header_word_1;
        logic [15:0] header_word_2;
        logic [15:0] header_word_3;
        logic [15:0] correction_word;
        logic        correction_used;
        logic [15:0] total_length;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/phcb_in_if.sv
`default_nettype none

interface phcb_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sequence_number;

    modport source (output valid, output sequence_number, input ready);
    modport sink (input valid, input sequence_number, output ready);
endinterface

`default_nettype wire

>>> rtl/core/phcb_out_if.sv
`default_nettype none

interface phcb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] header_word_0;
    logic [15:0] header_word_1;
    logic [15:0] header_word_2;
    logic [15:0] header_word_3;
    logic [15:0] correction_word;
    logic        correction_used;
    logic [15:0] total_length;

    modport source
    (
        output valid, output header_word_0, output header_word_1, output header_word_2,
        output header_word_3, output correction_word, output correction_used,
        output total_length, input ready
    );
    modport sink
    (
        input valid, input header_word_0, input header_word_1, input header_word_2,
        input header_word_3, input correction_word, input correction_used,
        input total_length, output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/phcb_cfg_regs.sv
`default_nettype none

module phcb_cfg_regs
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [phcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [phcb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output phcb_pkg::cfg_t                           cfg
);

    phcb_pkg::cfg_t cfg_reg;
    phcb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                phcb_pkg::REG_PROTOCOL_MODE:
                    cfg_next.protocol_mode = phcb_pkg::proto_mode_t'(cfg_wdata[0]);
                phcb_pkg::REG_DST_PORT:            cfg_next.dst_port = cfg_wdata[15:0];
                phcb_pkg::REG_SRC_PORT:            cfg_next.src_port = cfg_wdata[15:0];
                phcb_pkg::REG_PROCESS_ID:          cfg_next.process_id = cfg_wdata[15:0];
                phcb_pkg::REG_SOURCE_ADDRESS:      cfg_next.source_address = cfg_wdata;
                phcb_pkg::REG_DESTINATION_ADDRESS: cfg_next.destination_address = cfg_wdata;
                phcb_pkg::REG_FILL_BYTE:           cfg_next.fill_byte = cfg_wdata[7:0];
                phcb_pkg::REG_PROBE_LENGTH:        cfg_next.probe_length = cfg_wdata[15:0];
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.protocol_mode       <= phcb_pkg::MODE_ICMP;
            cfg_reg.dst_port            <= '0;
            cfg_reg.src_port            <= '0;
            cfg_reg.process_id          <= '0;
            cfg_reg.source_address      <= '0;
            cfg_reg.destination_address <= '0;
            cfg_reg.fill_byte           <= '0;
            cfg_reg.probe_length        <= phcb_pkg::PROBE_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/phcb_calc.sv
`default_nettype none

module phcb_calc
(
    input  wire phcb_pkg::cfg_t cfg,
    input  wire logic [15:0]    sequence_number,
    output phcb_pkg::result_t   result
);

    function automatic logic [15:0] fold_complement(input logic [32:0] sum);
        logic [17:0] s1;
        logic [16:0] s2;
        logic [15:0] s3;
        s1 = 18'(sum[32:16]) + 18'(sum[15:0]);
        s2 = 17'(s1[17:16]) + 17'(s1[15:0]);
        s3 = s2[15:0] + 16'(s2[16]);
        return ~s3;
    endfunction

    logic        is_udp;
    logic        seq_in_cksum;
    logic [15:0] min_len;
    logic [15:0] len;
    logic [15:0] fill_start;
    logic [15:0] fill_bytes;
    logic [15:0] fill_word;
    logic [30:0] pair_sum;
    logic [31:0] fill_sum;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w3_in;
    logic [32:0] header_sum;
    logic [32:0] total_sum;
    logic [15:0] cksum;

    always_comb
    begin
        is_udp       = (cfg.protocol_mode == phcb_pkg::MODE_UDP);
        seq_in_cksum = is_udp && (cfg.dst_port != '0) && (cfg.src_port != '0)
                       && (sequence_number != '0);
        min_len      = is_udp ? phcb_pkg::UDP_MIN_LEN : phcb_pkg::ICMP_MIN_LEN;
        len          = (cfg.probe_length < min_len) ? min_len : cfg.probe_length;

        // Fill bytes pair up into words holding the byte twice; an odd tail
        // byte lands in the high half of its word.
        fill_start = seq_in_cksum ? phcb_pkg::CORR_FILL_START : phcb_pkg::HDR_BYTES;
        fill_bytes = len - fill_start;
        fill_word  = {cfg.fill_byte, cfg.fill_byte};
        pair_sum   = fill_bytes[15:1] * fill_word;
        fill_sum   = 32'(pair_sum) + (fill_bytes[0] ? {16'h0000, cfg.fill_byte, 8'h00} : 32'h0);

        if (!is_udp)
        begin
            w0    = phcb_pkg::ICMP_ECHO_WORD;
            w1    = '0;
            w3_in = sequence_number;
            header_sum = 33'(w0) + 33'(cfg.process_id) + 33'(sequence_number);
        end
        else
        begin
            if (cfg.dst_port != '0)
            begin
                w1 = cfg.dst_port;
                if (cfg.src_port != '0)
                begin
                    w0    = cfg.src_port;
                    w3_in = sequence_number;
                end
                else
                begin
                    w0    = sequence_number;
                    w3_in = '0;
                end
            end
            else
            begin
                w1    = sequence_number;
                w0    = (cfg.src_port != '0) ? cfg.src_port : cfg.process_id;
                w3_in = '0;
            end
            // The pseudo-header length and the header length field are both len.
            header_sum = 33'(cfg.source_address[31:16]) + 33'(cfg.source_address[15:0])
                       + 33'(cfg.destination_address[31:16])
                       + 33'(cfg.destination_address[15:0])
                       + 33'(phcb_pkg::UDP_PROTO_NUM) + 33'(len) + 33'(len)
                       + 33'(w0) + 33'(w1) + 33'(w3_in);
        end

        total_sum = header_sum + 33'(fill_sum);
        cksum     = fold_complement(total_sum);

        result.total_length    = len;
        result.header_word_0   = w0;
        if (!is_udp)
        begin
            result.header_word_1   = cksum;
            result.header_word_2   = cfg.process_id;
            result.header_word_3   = sequence_number;
            result.correction_word = '0;
            result.correction_used = 1'b0;
        end
        else
        begin
            result.header_word_1 = w1;
            result.header_word_2 = len;
            if (seq_in_cksum)
            begin
                result.header_word_3   = sequence_number;
                result.correction_word = cksum;
                result.correction_used = 1'b1;
            end
            else
            begin
                result.header_word_3   = (cksum == '0) ? phcb_pkg::ALL_ONES_WORD : cksum;
                result.correction_word = '0;
                result.correction_used = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/probe_header_checksum_builder_unit.sv
`default_nettype none

// Builds the four header words of an IPv4 ICMP echo or UDP probe for each
// sequence number word, with the Internet checksum over the header, the
// fill-byte payload and, for UDP, the pseudo-header. A word is registered on
// entry, the header and checksum are formed in one pass through one 15x16
// multiplier and an adder tree, and the result is registered on exit. One
// word per cycle is sustained while the output is taken. The output register
// lets a new word enter while a result waits to be taken. The user must write
// the configuration registers through the cfg_wr_en, cfg_index and cfg_wdata
// port only while no word is in flight; the block does not enforce this.
module probe_header_checksum_builder_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    phcb_in_if.sink                                  probe_in,
    phcb_out_if.source                               probe_out,
    input  wire logic                                cfg_wr_en,
    input  wire logic [phcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [phcb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    phcb_pkg::cfg_t    cfg;
    phcb_pkg::result_t calc_result;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [15:0]       seq_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    phcb_pkg::result_t out_data_reg;
    logic              out_free;
    logic              in_fire;

    phcb_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    phcb_calc u_calc
    (
        .cfg             (cfg),
        .sequence_number (seq_reg),
        .result          (calc_result)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || probe_out.ready;
        probe_in.ready = !in_valid_reg || out_free;
        in_fire        = probe_in.valid && probe_in.ready;
        in_valid_next  = in_fire ? 1'b1 : (out_free ? 1'b0 : in_valid_reg);
        out_valid_next = out_free ? in_valid_reg : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            seq_reg <= probe_in.sequence_number;
        end
        if (out_free && in_valid_reg)
        begin
            out_data_reg <= calc_result;
        end
    end

    assign probe_out.valid           = out_valid_reg;
    assign probe_out.header_word_0   = out_data_reg.header_word_0;
    assign probe_out.header_word_1   = out_data_reg.header_word_1;
    assign probe_out.header_word_2   = out_data_reg.header_word_2;
    assign probe_out.header_word_3   = out_data_reg.header_word_3;
    assign probe_out.correction_word = out_data_reg.correction_word;
    assign probe_out.correction_used = out_data_reg.correction_used;
    assign probe_out.total_length    = out_data_reg.total_length;

endmodule

`default_nettype wire

>>> rtl/core/phcb_checker.sv
`default_nettype none

module phcb_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] header_word_2,
    input wire logic [15:0] header_word_3,
    input wire logic [15:0] correction_word,
    input wire logic        correction_used,
    input wire logic [15:0] total_length
);

    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output word dropped while stalled.");

    a_stall_holds_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(header_word_3) && $stable(total_length)
            && $stable(correction_word))
        else $error("Output payload changed while stalled.");

    a_no_correction_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !correction_used |-> correction_word == 16'h0000)
        else $error("Correction word set without correction.");

    a_correction_is_udp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && correction_used |-> header_word_3 != 16'h0000
            && header_word_2 == total_length && total_length >= 16'd12)
        else $error("Correction on a word that is not a UDP probe with a sequence.");

endmodule

bind probe_header_checksum_builder_unit phcb_checker u_phcb_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (probe_out.valid),
    .out_ready       (probe_out.ready),
    .header_word_2   (probe_out.header_word_2),
    .header_word_3   (probe_out.header_word_3),
    .correction_word (probe_out.correction_word),
    .correction_used (probe_out.correction_used),
    .total_length    (probe_out.total_length)
);

`default_nettype wire
